// File: design/lrb_pkg.sv
// lrb_pkg: shared types and constants for the lut remap / blend block
// no dependencies; imported by lrb_front, lrb_back and the top level, not by lrb_fifo

package lrb_pkg;

    localparam int CFG_W      = 13;
    localparam int IDX_W      = 2;
    localparam int COORD_W    = 12;
    localparam int WEIGHT_W   = 7;
    localparam int PIX_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int NUM_BYTES  = PIX_W / BYTE_W;
    localparam int OFFSET_W   = 25;
    localparam int S_TDATA_W  = 104;
    localparam int M_TDATA_W  = 64;

    // byte times weight, and sum of two of them
    localparam int WPROD_W    = BYTE_W + WEIGHT_W;
    localparam int BSUM_W     = WPROD_W + 1;

    // divide by 100 as multiply by ceil(2^23/100), exact for sums below 2^16
    localparam int RECIP_SHIFT        = 23;
    localparam int RECIP_W            = 17;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 17'd83887;
    localparam int RPROD_W            = BSUM_W + RECIP_W;

    localparam logic [CFG_W-1:0] OUT_WIDTH_RST  = 13'd1024;
    localparam logic [CFG_W-1:0] OUT_HEIGHT_RST = 13'd768;
    localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 13'd720;
    localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 13'd576;

    typedef enum logic [IDX_W-1:0] {
        REG_OUT_WIDTH  = 2'd0,
        REG_OUT_HEIGHT = 2'd1,
        REG_SRC_WIDTH  = 2'd2,
        REG_SRC_HEIGHT = 2'd3
    } cfg_reg_t;

    // classified pixel pair handed from front to back
    typedef struct packed {
        logic                blend;
        logic [WEIGHT_W-1:0] weight_a;
        logic [WEIGHT_W-1:0] weight_b;
        logic                write_enable;
        logic                frame_end;
        logic [PIX_W-1:0]    pixel_a;
        logic [PIX_W-1:0]    pixel_b;
    } pix_entry_t;

endpackage

// File: design/lrb_fifo.sv
// lrb_fifo: small register queue between front and back of the remap block
// standalone; no package needed

module lrb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             not_full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/lrb_front.sv
// lrb_front: config registers, raster counters and bounds check for each accepted entry
// depends on lrb_pkg; feeds lrb_fifo

module lrb_front #(
    parameter int MAX_SIDE = 4096,
    localparam int CNT_W  = $clog2(MAX_SIDE),
    localparam int SIDE_W = $clog2(MAX_SIDE + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lrb_pkg::IDX_W-1:0]       cfg_index,
    input  logic [lrb_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lrb_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            q_not_full,
    output logic                            q_push,
    output lrb_pkg::pix_entry_t             q_entry,
    output logic [CNT_W-1:0]                q_row,
    output logic [CNT_W-1:0]                q_col,
    output logic [SIDE_W-1:0]               q_side
);

    import lrb_pkg::*;

    logic [CFG_W-1:0]   out_width_reg, out_height_reg, src_width_reg, src_height_reg;
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   row_reg, row_next;
    logic [SIDE_W-1:0]  side_w, side_h;
    logic [SIDE_W:0]    col_step, row_step;
    logic               col_wrap, row_wrap;
    logic               accept;
    logic [COORD_W-1:0] coord_x, coord_y;

    assign cfg_ready = 1'b1;
    assign s_tready  = q_not_full;
    assign accept    = s_tvalid & q_not_full;
    assign q_push    = accept;

    // sizes above the supported side act as the side itself
    assign side_w = (32'(out_width_reg) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                         : SIDE_W'(out_width_reg);
    assign side_h = (32'(out_height_reg) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                          : SIDE_W'(out_height_reg);

    assign col_step = (SIDE_W + 1)'(col_reg) + (SIDE_W + 1)'(2);
    assign row_step = (SIDE_W + 1)'(row_reg) + (SIDE_W + 1)'(1);
    assign col_wrap = (col_step >= (SIDE_W + 1)'(side_w));
    assign row_wrap = (row_step >= (SIDE_W + 1)'(side_h));

    assign coord_x = s_tdata[25:14];
    assign coord_y = s_tdata[37:26];

    always_comb
    begin
        q_entry.blend        = s_tuser;
        q_entry.weight_a     = s_tdata[6:0];
        q_entry.weight_b     = s_tdata[13:7];
        q_entry.write_enable = (CFG_W'(coord_x) < src_width_reg) &&
                               (CFG_W'(coord_y) < src_height_reg);
        q_entry.frame_end    = col_wrap & row_wrap;
        q_entry.pixel_a      = s_tdata[69:38];
        q_entry.pixel_b      = s_tdata[101:70];
    end

    assign q_row  = row_reg;
    assign q_col  = col_reg;
    assign q_side = side_w;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : CNT_W'(row_step);
            end
            else
            begin
                col_next = CNT_W'(col_step);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_width_reg  <= OUT_WIDTH_RST;
            out_height_reg <= OUT_HEIGHT_RST;
            src_width_reg  <= SRC_WIDTH_RST;
            src_height_reg <= SRC_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_OUT_WIDTH:  out_width_reg  <= cfg_data;
                REG_OUT_HEIGHT: out_height_reg <= cfg_data;
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

endmodule

// File: design/lrb_back.sv
// lrb_back: offset multiply, per-byte weighted blend and output register
// depends on lrb_pkg; drains lrb_fifo

module lrb_back #(
    parameter int MAX_SIDE = 4096,
    localparam int CNT_W  = $clog2(MAX_SIDE),
    localparam int SIDE_W = $clog2(MAX_SIDE + 1),
    localparam int MUL_W  = CNT_W + SIDE_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_not_empty,
    output logic                            q_pop,
    input  lrb_pkg::pix_entry_t             q_entry,
    input  logic [CNT_W-1:0]                q_row,
    input  logic [CNT_W-1:0]                q_col,
    input  logic [SIDE_W-1:0]               q_side,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lrb_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);

    import lrb_pkg::*;

    logic                s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic                s1_ready, s2_ready, out_ready;

    // stage 1: products
    logic [WPROD_W-1:0]  s1_prod_a_reg [NUM_BYTES];
    logic [WPROD_W-1:0]  s1_prod_b_reg [NUM_BYTES];
    logic [MUL_W-1:0]    s1_rowmul_reg;
    logic [CNT_W-1:0]    s1_col_reg;
    pix_entry_t          s1_entry_reg;

    // stage 2: divided bytes and offset
    logic [BYTE_W-1:0]   s2_byte_reg [NUM_BYTES];
    logic [OFFSET_W-1:0] s2_offset_reg;
    pix_entry_t          s2_entry_reg;

    logic [BSUM_W-1:0]   bsum [NUM_BYTES];
    logic [RPROD_W-1:0]  rprod [NUM_BYTES];
    logic [MUL_W:0]      pos_sum;
    logic [MUL_W+1:0]    byte_pos;
    logic [PIX_W-1:0]    blend_word, word_sel;

    logic [OFFSET_W-1:0] out_offset_reg;
    logic [PIX_W-1:0]    out_word_reg;
    logic                out_we_reg, out_last_reg;

    assign out_ready = !out_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign q_pop     = q_not_empty && s1_ready;

    always_comb
    begin
        for (int k = 0; k < NUM_BYTES; k++)
        begin
            bsum[k]  = BSUM_W'(s1_prod_a_reg[k]) + BSUM_W'(s1_prod_b_reg[k]);
            rprod[k] = RPROD_W'(bsum[k]) * RPROD_W'(RECIP_MUL);
        end
        pos_sum  = (MUL_W + 1)'(s1_rowmul_reg) + (MUL_W + 1)'(s1_col_reg);
        byte_pos = {pos_sum, 1'b0};
    end

    always_comb
    begin
        for (int k = 0; k < NUM_BYTES; k++)
        begin
            blend_word[k*BYTE_W +: BYTE_W] = s2_byte_reg[k];
        end
        if (!s2_entry_reg.write_enable)
        begin
            word_sel = '0;
        end
        else if (s2_entry_reg.blend)
        begin
            word_sel = blend_word;
        end
        else
        begin
            word_sel = s2_entry_reg.pixel_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= q_not_empty;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            for (int k = 0; k < NUM_BYTES; k++)
            begin
                s1_prod_a_reg[k] <= WPROD_W'(q_entry.pixel_a[k*BYTE_W +: BYTE_W]) *
                                    WPROD_W'(q_entry.weight_a);
                s1_prod_b_reg[k] <= WPROD_W'(q_entry.pixel_b[k*BYTE_W +: BYTE_W]) *
                                    WPROD_W'(q_entry.weight_b);
            end
            s1_rowmul_reg <= MUL_W'(q_row) * MUL_W'(q_side);
            s1_col_reg    <= q_col;
            s1_entry_reg  <= q_entry;
        end
        if (s2_ready)
        begin
            for (int k = 0; k < NUM_BYTES; k++)
            begin
                s2_byte_reg[k] <= rprod[k][RECIP_SHIFT +: BYTE_W];
            end
            s2_offset_reg <= OFFSET_W'(byte_pos);
            s2_entry_reg  <= s1_entry_reg;
        end
        if (out_ready)
        begin
            out_offset_reg <= s2_offset_reg;
            out_word_reg   <= word_sel;
            out_we_reg     <= s2_entry_reg.write_enable;
            out_last_reg   <= s2_entry_reg.frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_word_reg, out_offset_reg});
    assign m_tuser  = out_we_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: design/lut_remap_blend_yuyv_unit.sv
// lut_remap_blend_yuyv_unit: top level of the lut remap and alpha blend stage
// depends on lrb_pkg, lrb_front, lrb_fifo, lrb_back
//
// Usage:
//   s_* channel takes one lookup entry per transfer: s_tuser is the blend flag,
//   s_tdata carries weights, source coordinate and both fetched source words.
//   m_* channel gives one pixel pair per entry: byte offset and result word in
//   m_tdata, write enable in m_tuser, last pair of the frame on m_tlast.
//   cfg_* writes out_width, out_height, src_width, src_height (index 0..3);
//   write only while the block is drained.
// Timing:
//   an entry accepted on s_* passes the queue register, two arithmetic stages
//   (byte*weight products with the row*width product, then the reciprocal
//   multiply for the divide by 100) and the output register before it shows
//   on m_*; one entry per cycle sustained while m_tready stays high.
//   A four-entry queue sits between the front counters and the back stages.
// Reset: raster counters go to the top-left pair, sizes take their defaults,
//   all stages and the queue empty.
// Stall: when m_tready is low the back stages hold, the queue fills and
//   s_tready drops once it is full; nothing is dropped.

module lut_remap_blend_yuyv_unit #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lrb_pkg::IDX_W-1:0]       cfg_index,
    input  logic [lrb_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // weight_a, weight_b, coord_x, coord_y, pixel_a, pixel_b, zero pad
    input  logic [lrb_pkg::S_TDATA_W-1:0]   s_tdata,
    // blend_enable
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_offset, out_word, zero pad
    output logic [lrb_pkg::M_TDATA_W-1:0]   m_tdata,
    // write_enable
    output logic                            m_tuser,
    // frame_end
    output logic                            m_tlast
);

    import lrb_pkg::*;

    localparam int CNT_W   = $clog2(MAX_SIDE);
    localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
    localparam int ENTRY_W = $bits(pix_entry_t);
    localparam int Q_W     = ENTRY_W + 2 * CNT_W + SIDE_W;
    localparam int Q_DEPTH = 4;

    pix_entry_t        fr_entry, bk_entry;
    logic [CNT_W-1:0]  fr_row, fr_col, bk_row, bk_col;
    logic [SIDE_W-1:0] fr_side, bk_side;
    logic              q_push, q_pop, q_not_full, q_not_empty;
    logic [Q_W-1:0]    q_in, q_out;

    lrb_front #(.MAX_SIDE(MAX_SIDE)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_not_full (q_not_full),
        .q_push     (q_push),
        .q_entry    (fr_entry),
        .q_row      (fr_row),
        .q_col      (fr_col),
        .q_side     (fr_side)
    );

    assign q_in = {fr_entry, fr_row, fr_col, fr_side};

    lrb_fifo #(.WIDTH(Q_W), .DEPTH(Q_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_not_empty)
    );

    assign {bk_entry, bk_row, bk_col, bk_side} = q_out;

    lrb_back #(.MAX_SIDE(MAX_SIDE)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .q_entry     (bk_entry),
        .q_row       (bk_row),
        .q_col       (bk_col),
        .q_side      (bk_side),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

`ifndef ASSERT_OFF
    // a skipped write carries an all-zero word
    a_skip_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[56:25] == 32'd0)
        else $error("nonzero word on skipped write");

    // pixel pairs start on even byte offsets
    a_offset_even: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[0] == 1'b0)
        else $error("odd output offset");

    // a full queue is never empty at the same time
    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !q_not_full |-> q_not_empty)
        else $error("queue full and empty at once");
`endif

endmodule

// File: verif/tb_lut_remap_blend_yuyv_unit.sv
`timescale 1ns / 1ps
// tb_lut_remap_blend_yuyv_unit: self-checking bench for the lut remap and blend stage
// streams lookup entries, writes the size registers and checks every pixel pair
// depends on lrb_pkg and lut_remap_blend_yuyv_unit

module tb_lut_remap_blend_yuyv_unit;
    import lrb_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int SIDE_LIMIT = 4096;
    localparam int IDLE_LIMIT = 2000;
    localparam int PIPE_DEPTH = 8;
    localparam int LONG_HOLD  = 40;
    localparam int PERCENT    = 100;
    localparam int PAIR_STEP  = 2;

    typedef struct {
        logic                blend;
        logic [WEIGHT_W-1:0] weight_a;
        logic [WEIGHT_W-1:0] weight_b;
        logic [COORD_W-1:0]  coord_x;
        logic [COORD_W-1:0]  coord_y;
        logic [PIX_W-1:0]    pixel_a;
        logic [PIX_W-1:0]    pixel_b;
    } lut_entry_t;

    typedef struct {
        logic [OFFSET_W-1:0] offset;
        logic                write_enable;
        logic [PIX_W-1:0]    word;
        logic                frame_end;
    } pixel_pair_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    // shadow of the size registers and of the raster position
    logic [CFG_W-1:0]   out_width_q;
    logic [CFG_W-1:0]   out_height_q;
    logic [CFG_W-1:0]   src_width_q;
    logic [CFG_W-1:0]   src_height_q;
    logic [COORD_W-1:0] column_pos;
    logic [COORD_W-1:0] row_pos;

    pixel_pair_t pending_pairs[$];
    int          error_count   = 0;
    bit          bursts_on     = 1'b1;
    int          sink_hold_req = 0;

    lut_remap_blend_yuyv_unit #(
        .MAX_SIDE(SIDE_LIMIT)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // next pixel pair of the raster walk, advances the shadow position
    function automatic pixel_pair_t remap_pixel_pair(lut_entry_t e);
        pixel_pair_t r;
        int unsigned w;
        int unsigned h;
        int unsigned sum;
        logic        col_wrap;
        logic        row_wrap;
        w = (out_width_q > SIDE_LIMIT) ? SIDE_LIMIT : out_width_q;
        h = (out_height_q > SIDE_LIMIT) ? SIDE_LIMIT : out_height_q;
        r.offset = OFFSET_W'((row_pos * w + column_pos) * PAIR_STEP);
        r.write_enable = (e.coord_x < src_width_q) && (e.coord_y < src_height_q);
        r.word = '0;
        if (r.write_enable)
        begin
            if (!e.blend)
                r.word = e.pixel_a;
            else
                for (int k = 0; k < NUM_BYTES; k++)
                begin
                    sum = e.pixel_a[k*BYTE_W +: BYTE_W] * e.weight_a
                        + e.pixel_b[k*BYTE_W +: BYTE_W] * e.weight_b;
                    r.word[k*BYTE_W +: BYTE_W] = BYTE_W'(sum / PERCENT);
                end
        end
        col_wrap = (column_pos + PAIR_STEP) >= w;
        row_wrap = (row_pos + 1) >= h;
        r.frame_end = col_wrap && row_wrap;
        if (col_wrap)
        begin
            column_pos = '0;
            row_pos = row_wrap ? '0 : row_pos + 1'b1;
        end
        else
            column_pos = COORD_W'(column_pos + PAIR_STEP);
        return r;
    endfunction

    function automatic lut_entry_t make_entry(bit blend, int unsigned wa, int unsigned wb,
                                              int unsigned cx, int unsigned cy,
                                              logic [PIX_W-1:0] pa, logic [PIX_W-1:0] pb);
        lut_entry_t e;
        e.blend    = blend;
        e.weight_a = WEIGHT_W'(wa);
        e.weight_b = WEIGHT_W'(wb);
        e.coord_x  = COORD_W'(cx);
        e.coord_y  = COORD_W'(cy);
        e.pixel_a  = pa;
        e.pixel_b  = pb;
        return e;
    endfunction

    function automatic lut_entry_t random_entry();
        lut_entry_t  e;
        int unsigned x_bound;
        int unsigned y_bound;
        e.blend = 1'($urandom_range(0, 1));
        // mostly weights that sum to 100, now and then anything the field holds
        e.weight_a = WEIGHT_W'($urandom_range(0, PERCENT));
        e.weight_b = WEIGHT_W'(PERCENT - e.weight_a);
        if ($urandom_range(0, 3) == 0)
        begin
            e.weight_a = WEIGHT_W'($urandom_range(0, 127));
            e.weight_b = WEIGHT_W'($urandom_range(0, 127));
        end
        x_bound = (src_width_q > 4095) ? 4095 : src_width_q;
        y_bound = (src_height_q > 4095) ? 4095 : src_height_q;
        if ($urandom_range(0, 4) == 0)
        begin
            e.coord_x = COORD_W'($urandom_range(0, 4095));
            e.coord_y = COORD_W'($urandom_range(0, 4095));
        end
        else
        begin
            e.coord_x = COORD_W'($urandom_range(0, x_bound));
            e.coord_y = COORD_W'($urandom_range(0, y_bound));
        end
        e.pixel_a = $urandom;
        e.pixel_b = $urandom;
        return e;
    endfunction

    task automatic send_entry(lut_entry_t e);
        s_tuser  <= e.blend;
        s_tdata  <= {2'b00, e.pixel_b, e.pixel_a, e.coord_y, e.coord_x,
                     e.weight_b, e.weight_a};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        pending_pairs.push_back(remap_pixel_pair(e));
        if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_random_entries(int count);
        repeat (count) send_entry(random_entry());
    endtask

    // stop offering entries and wait for every pair still owed
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_pairs.size() != 0);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned value);
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_OUT_WIDTH:  out_width_q  = CFG_W'(value);
            REG_OUT_HEIGHT: out_height_q = CFG_W'(value);
            REG_SRC_WIDTH:  src_width_q  = CFG_W'(value);
            REG_SRC_HEIGHT: src_height_q = CFG_W'(value);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_sizes(int unsigned ow, int unsigned oh, int unsigned sw, int unsigned sh);
        write_reg(REG_OUT_WIDTH, ow);
        write_reg(REG_OUT_HEIGHT, oh);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
    endtask

    task automatic set_random_sizes();
        int unsigned ow;
        int unsigned oh;
        int unsigned sw;
        int unsigned sh;
        case ($urandom_range(0, 4))
            0:
            begin
                ow = PAIR_STEP * $urandom_range(1, 32);
                oh = $urandom_range(1, 8);
            end
            1:
            begin
                ow = $urandom_range(0, 8191);
                oh = $urandom_range(0, 8191);
            end
            2:
            begin
                ow = SIDE_LIMIT;
                oh = SIDE_LIMIT;
            end
            default:
            begin
                ow = $urandom_range(0, 40);
                oh = $urandom_range(0, 6);
            end
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            sw = $urandom_range(0, 8191);
            sh = $urandom_range(0, 8191);
        end
        else
        begin
            sw = $urandom_range(1, 4096);
            sh = $urandom_range(1, 4096);
        end
        set_sizes(ow, oh, sw, sh);
    endtask

    function automatic void check_field(string field, logic [PIX_W-1:0] expected,
                                        logic [PIX_W-1:0] actual);
        if (actual !== expected)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, expected, actual);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_pairs
        pixel_pair_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pairs.size() == 0)
            begin
                $display("%0t: pair with nothing owed, expected none actual offset %h word %h",
                         $time, m_tdata[OFFSET_W-1:0], m_tdata[OFFSET_W +: PIX_W]);
                error_count++;
            end
            else
            begin
                want = pending_pairs.pop_front();
                check_field("out_offset", PIX_W'(want.offset), PIX_W'(m_tdata[OFFSET_W-1:0]));
                check_field("write_enable", PIX_W'(want.write_enable), PIX_W'(m_tuser));
                check_field("out_word", want.word, m_tdata[OFFSET_W +: PIX_W]);
                check_field("frame_end", PIX_W'(want.frame_end), PIX_W'(m_tlast));
            end
        end
    end

    // output side: short random stalls plus the long hold-off on request
    initial
    begin : sink_ready
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req > 0)
            begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_lut_remap_blend_yuyv_unit: FAIL");
        $finish;
    end

    task automatic test_default_sizes();
        send_entry(make_entry(0, 0, 0, 0, 0, 32'h0000_0000, 32'hFFFF_FFFF));
        send_entry(make_entry(0, 100, 0, 719, 575, 32'hFFFF_FFFF, 32'h0000_0000));
        // just outside the source frame, word must be zero
        send_entry(make_entry(0, 50, 50, 720, 0, 32'h1234_5678, 32'h0000_0000));
        send_entry(make_entry(1, 50, 50, 0, 576, 32'h8765_4321, 32'hFFFF_FFFF));
        send_entry(make_entry(1, 100, 0, 10, 20, 32'hA5C3_0FF0, 32'h5A3C_F00F));
        send_entry(make_entry(1, 0, 100, 30, 40, 32'hA5C3_0FF0, 32'h5A3C_F00F));
        send_entry(make_entry(1, 50, 50, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // weights above 100 overflow the byte
        send_entry(make_entry(1, 127, 127, 2, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_entry(make_entry(1, 0, 0, 3, 3, 32'hDEAD_BEEF, 32'hCAFE_F00D));
        send_entry(make_entry(1, 127, 127, 4095, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        wait_drained();
    endtask

    task automatic test_frame_wrap();
        set_sizes(2, 1, 1, 1);
        send_entry(make_entry(0, 0, 0, 0, 0, 32'h0102_0304, 32'h0));
        send_entry(make_entry(0, 0, 0, 1, 0, 32'h0102_0304, 32'h0));
        wait_drained();
        // odd width
        set_sizes(5, 2, 4096, 4096);
        send_random_entries(6);
        wait_drained();
        // zero sizes everywhere
        set_sizes(0, 0, 0, 0);
        send_random_entries(2);
        wait_drained();
        set_sizes(1, 3, 8191, 8191);
        send_random_entries(2);
        wait_drained();
    endtask

    task automatic test_size_shrink();
        // oversized frame acts as the largest side
        set_sizes(8191, 8191, 720, 576);
        send_random_entries(3);
        wait_drained();
        set_sizes(4, 1, 720, 576);
        send_random_entries(2);
        wait_drained();
    endtask

    task automatic test_random_sizes(int phases, int count);
        repeat (phases)
        begin
            set_random_sizes();
            send_random_entries(count);
            wait_drained();
        end
    endtask

    task automatic test_output_backpressure();
        set_sizes(PAIR_STEP * 6, 3, 2048, 2048);
        sink_hold_req = LONG_HOLD;
        send_random_entries(100);
        wait_drained();
    endtask

    task automatic test_sender_pause();
        set_random_sizes();
        send_random_entries(100);
        // hold the stream until the block is empty, then resume mid-frame
        wait_drained();
        send_random_entries(100);
        wait_drained();
    endtask

    task automatic test_steady_stream();
        bursts_on = 1'b0;
        set_random_sizes();
        send_random_entries(250);
        wait_drained();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        out_width_q  = OUT_WIDTH_RST;
        out_height_q = OUT_HEIGHT_RST;
        src_width_q  = SRC_WIDTH_RST;
        src_height_q = SRC_HEIGHT_RST;
        column_pos   = '0;
        row_pos      = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_sizes();
        test_frame_wrap();
        test_size_shrink();
        test_random_sizes(5, 250);
        test_output_backpressure();
        test_sender_pause();
        test_steady_stream();

        wait_drained();
        repeat (PIPE_DEPTH) @(posedge clk);
        if (error_count == 0 && pending_pairs.size() == 0)
            $display("tb_lut_remap_blend_yuyv_unit: PASS");
        else
            $display("tb_lut_remap_blend_yuyv_unit: FAIL");
        $finish;
    end

endmodule
